>>> sv/eetd_pkg.sv
// Shared types and constants of the engine event trigger detector.
package eetd_pkg;

  localparam int unsigned CdW   = 20;
  localparam int unsigned RpmW  = 15;
  localparam int unsigned LvlW  = 16;
  localparam int unsigned GearW = 5;
  localparam int unsigned TrqW  = 16;
  localparam int unsigned DltW  = 21;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegRedline    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegImpactLvl  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRearmLvl   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegHeavyLvl   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegOverrunRpm = 3'd4;

  localparam logic [RpmW-1:0] RedlineReset    = 15'd7000;
  localparam logic [LvlW-1:0] ImpactLvlReset  = 16'd1556;
  localparam logic [LvlW-1:0] RearmLvlReset   = 16'd1147;
  localparam logic [LvlW-1:0] HeavyLvlReset   = 16'd4096;
  localparam logic [RpmW-1:0] OverrunRpmReset = 15'd2600;

  localparam logic [CdW-1:0] DeltaMaxUs      = 20'd1000000;
  localparam logic [CdW-1:0] HeavyReloadUs   = 20'd280000;
  localparam logic [CdW-1:0] LightReloadUs   = 20'd180000;
  localparam logic [CdW-1:0] LimiterReloadUs = 20'd105000;
  localparam logic [CdW-1:0] OverrunReloadUs = 20'd220000;

  localparam logic [RpmW-1:0] RedlineFloor  = 15'd500;
  localparam logic [RpmW-1:0] LimiterMargin = 15'd25;
  localparam logic signed [TrqW-1:0] PopHighTenths = 16'sd80;
  localparam logic signed [TrqW-1:0] PopLowTenths  = -16'sd40;

  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 8;

  typedef struct packed {
    logic [RpmW-1:0] redline_rpm;
    logic [LvlW-1:0] impact_level;
    logic [LvlW-1:0] rearm_level;
    logic [LvlW-1:0] heavy_level;
    logic [RpmW-1:0] overrun_min_rpm;
  } cfg_t;

  typedef struct packed {
    logic [DltW-1:0]         delta_us;
    logic [GearW-1:0]        gear_number;
    logic signed [LvlW-1:0]  activity_q12;
    logic                    activity_finite;
    logic [RpmW-1:0]         engine_rpm;
    logic signed [TrqW-1:0]  torque_tenths;
    logic                    torque_finite;
  } frame_t;

  typedef struct packed {
    logic                   seen_first;
    logic [GearW-1:0]       last_gear;
    logic [LvlW-1:0]        last_activity;
    logic signed [TrqW-1:0] last_torque;
    logic [CdW-1:0]         impact_cooldown;
    logic [CdW-1:0]         limiter_cooldown;
    logic [CdW-1:0]         overrun_cooldown;
  } state_t;

  typedef struct packed {
    logic overrun_pop;
    logic limiter_cut;
    logic impact_heavy;
    logic impact_light;
    logic gear_shift;
  } flags_t;

endpackage

>>> sv/eetd_eval.sv
// Per-frame event evaluation: cooldown countdown, triggers and next state.
module eetd_eval import eetd_pkg::*; (
  input  frame_t frame_i,
  input  state_t state_i,
  input  cfg_t   cfg_i,
  output state_t state_o,
  output flags_t flags_o
);

  logic [CdW-1:0]  delta;
  logic [CdW-1:0]  imp_cd, lim_cd, ovr_cd;
  logic [LvlW-1:0] activity;
  logic [RpmW-1:0] redline, cut_rpm;
  logic            impact_hit, heavy, cut_hit, pop_hit;

  always_comb begin
    if (frame_i.delta_us > {1'b0, DeltaMaxUs}) begin
      delta = DeltaMaxUs;
    end else begin
      delta = frame_i.delta_us[CdW-1:0];
    end
    imp_cd = (state_i.impact_cooldown  > delta) ? state_i.impact_cooldown  - delta : '0;
    lim_cd = (state_i.limiter_cooldown > delta) ? state_i.limiter_cooldown - delta : '0;
    ovr_cd = (state_i.overrun_cooldown > delta) ? state_i.overrun_cooldown - delta : '0;

    // negative or non-finite activity reads as zero
    activity = (frame_i.activity_finite && !frame_i.activity_q12[LvlW-1])
             ? frame_i.activity_q12 : '0;

    redline = (cfg_i.redline_rpm < RedlineFloor) ? RedlineFloor : cfg_i.redline_rpm;
    cut_rpm = redline - LimiterMargin;

    impact_hit = state_i.seen_first && (activity > cfg_i.impact_level)
              && (state_i.last_activity <= cfg_i.rearm_level) && (imp_cd == '0);
    heavy      = activity >= cfg_i.heavy_level;
    cut_hit    = state_i.seen_first && (frame_i.engine_rpm >= cut_rpm) && (lim_cd == '0);
    pop_hit    = state_i.seen_first && (state_i.last_torque > PopHighTenths)
              && frame_i.torque_finite && (frame_i.torque_tenths < PopLowTenths)
              && (frame_i.engine_rpm > cfg_i.overrun_min_rpm) && (ovr_cd == '0);

    flags_o.gear_shift   = state_i.seen_first && (frame_i.gear_number != state_i.last_gear);
    flags_o.impact_light = impact_hit && !heavy;
    flags_o.impact_heavy = impact_hit && heavy;
    flags_o.limiter_cut  = cut_hit;
    flags_o.overrun_pop  = pop_hit;

    state_o.seen_first       = 1'b1;
    state_o.last_gear        = frame_i.gear_number;
    state_o.last_activity    = activity;
    state_o.last_torque      = frame_i.torque_finite ? frame_i.torque_tenths : '0;
    state_o.impact_cooldown  = impact_hit ? (heavy ? HeavyReloadUs : LightReloadUs) : imp_cd;
    state_o.limiter_cooldown = cut_hit ? LimiterReloadUs : lim_cd;
    state_o.overrun_cooldown = pop_hit ? OverrunReloadUs : ovr_cd;
  end

endmodule

>>> sv/engine_event_trigger_detector_unit.sv
// Engine event trigger detector: one telemetry frame in, one set of event flags out.
// Takes one item per clock while m_axis_tready does not stall it: an input register holds
// the frame, a single pass of compares and subtracts against the stored state
// (previous gear, activity, torque and three cooldown timers) produces the flags,
// and a result register presents them; state advances as the item leaves the
// input register, so back-to-back items see each other's updates. Configuration
// writes are taken in any cycle (ready is always high) and must be issued only
// while no item is in flight.
module engine_event_trigger_detector_unit import eetd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // delta_us[20:0], gear_number[25:21], activity_q12[41:26], activity_finite[42],
  // engine_rpm[57:43], torque_tenths[73:58], torque_finite[74], zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // gear_shift[0], impact_light[1], impact_heavy[2], limiter_cut[3],
  // overrun_pop[4], zero pad
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t   cfg_q;
  state_t state_q, state_d;
  frame_t frame_q, frame_in;
  flags_t flags_q, flags_d;
  logic   in_valid_q, out_valid_q;
  logic   advance, load;

  assign frame_in.delta_us        = s_axis_tdata[20:0];
  assign frame_in.gear_number     = s_axis_tdata[25:21];
  assign frame_in.activity_q12    = s_axis_tdata[41:26];
  assign frame_in.activity_finite = s_axis_tdata[42];
  assign frame_in.engine_rpm      = s_axis_tdata[57:43];
  assign frame_in.torque_tenths   = s_axis_tdata[73:58];
  assign frame_in.torque_finite   = s_axis_tdata[74];

  // advance the held frame when the result register is free or being drained
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign load          = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  eetd_eval u_eval (
    .frame_i (frame_q),
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .state_o (state_d),
    .flags_o (flags_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.redline_rpm     <= RedlineReset;
      cfg_q.impact_level    <= ImpactLvlReset;
      cfg_q.rearm_level     <= RearmLvlReset;
      cfg_q.heavy_level     <= HeavyLvlReset;
      cfg_q.overrun_min_rpm <= OverrunRpmReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegRedline:    cfg_q.redline_rpm     <= cfg_data_i[RpmW-1:0];
        RegImpactLvl:  cfg_q.impact_level    <= cfg_data_i;
        RegRearmLvl:   cfg_q.rearm_level     <= cfg_data_i;
        RegHeavyLvl:   cfg_q.heavy_level     <= cfg_data_i;
        RegOverrunRpm: cfg_q.overrun_min_rpm <= cfg_data_i[RpmW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      frame_q <= frame_in;
    end
    if (advance) begin
      flags_q <= flags_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-5){1'b0}}, flags_q};

endmodule
